[design/rpg_pkg.sv]
// shared types, codes and defaults of the response policy gate
package rpg_pkg;

    // log sizing
    localparam int LOG_DEPTH_DEFAULT = 16;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENFORCE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONFIDENCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACTIONS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_MASK     = 3'd4;

    // register reset values
    localparam logic        ENFORCE_MODE_RST   = 1'b0;
    localparam logic [10:0] MIN_CONFIDENCE_RST = 11'd717;
    localparam logic [4:0]  MAX_ACTIONS_RST    = 5'd5;
    localparam logic [15:0] WINDOW_SECONDS_RST = 16'd300;
    localparam logic [3:0]  ALLOW_MASK_RST     = 4'd0;

    // response codes
    localparam logic [2:0] RESP_OBSERVE    = 3'd0;
    localparam logic [2:0] RESP_KILL       = 3'd1;
    localparam logic [2:0] RESP_QUARANTINE = 3'd2;
    localparam logic [2:0] RESP_BLOCK_NET  = 3'd3;
    localparam logic [2:0] RESP_PREVENT    = 3'd4;

    // reason codes
    localparam logic [2:0] RSN_NONE      = 3'd0;
    localparam logic [2:0] RSN_UNDEFINED = 3'd1;
    localparam logic [2:0] RSN_LOW_CONF  = 3'd2;
    localparam logic [2:0] RSN_OBSERVE   = 3'd3;
    localparam logic [2:0] RSN_RATE_LIM  = 3'd4;
    localparam logic [2:0] RSN_BLOCKED   = 3'd5;

    typedef struct packed {
        logic        has_resp;
        logic [10:0] confidence;
        logic [2:0]  req_action;
        logic [31:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0] prop_action;
        logic [2:0] final_action;
        logic       permitted;
        logic [2:0] reason;
    } t_out_item;

endpackage

[design/response_policy_gate_with_rate_limit_core.sv]
// response policy gate with sliding-window log rate limiter, top level
// each transaction passes through the input register, then the result register
// throughput: one transaction per cycle unless the result channel stalls; the log
//   compare, popcount and update resolve combinationally between those registers
// reset: synchronous active-low; clears valid flags, log valid bits, write slot and
//   config registers to their defaults; log timestamps are not reset
module response_policy_gate_with_rate_limit_core #(
    parameter int LOG_DEPTH = rpg_pkg::LOG_DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [rpg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rpg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rpg_pkg::t_in_item                 i_in_data,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rpg_pkg::t_out_item                o_out_data
);

    localparam int SLOT_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LOG_DEPTH - 1);

    // config registers
    logic        r_enforce_mode;
    logic [10:0] r_min_confidence;
    logic [4:0]  r_max_actions;
    logic [15:0] r_window_seconds;
    logic [3:0]  r_allow_mask;

    // pipeline registers
    logic                r_in_valid;
    rpg_pkg::t_in_item   r_in;
    logic                r_out_valid;
    rpg_pkg::t_out_item  r_out;

    // action log
    logic [31:0]          r_times [LOG_DEPTH];
    logic [LOG_DEPTH-1:0] r_entry_valid;
    logic [SLOT_W-1:0]    r_slot;

    logic                 fire;
    logic [31:0]          cutoff;
    logic [LOG_DEPTH-1:0] in_window;
    logic [CNT_W-1:0]     count;
    logic                 limited;
    logic                 allowed;
    logic                 do_log;
    rpg_pkg::t_out_item   n_out;
    logic [LOG_DEPTH-1:0] n_entry_valid;
    logic [SLOT_W-1:0]    n_slot;

    // process stage advances when the result register is free or drains
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // window start, saturating at zero
    assign cutoff = (r_in.now_time >= {16'd0, r_window_seconds})
                  ? r_in.now_time - {16'd0, r_window_seconds} : 32'd0;

    // entries still inside the window; same set survives eviction after logging
    always_comb begin
        for (int i = 0; i < LOG_DEPTH; i++) begin
            in_window[i] = r_entry_valid[i] && (r_times[i] >= cutoff);
        end
    end

    always_comb begin
        count = '0;
        for (int i = 0; i < LOG_DEPTH; i++) begin
            count = count + CNT_W'(in_window[i]);
        end
    end

    // limiting is off when either knob is zero
    assign limited = (r_max_actions != 5'd0) && (r_window_seconds != 16'd0)
                  && (CMP_W'(count) >= CMP_W'(r_max_actions));

    // evaluation then application
    always_comb begin
        n_out = '0;
        if (!r_in.has_resp) begin
            n_out.prop_action = rpg_pkg::RESP_OBSERVE;
            n_out.reason      = rpg_pkg::RSN_UNDEFINED;
        end else if (r_in.confidence < r_min_confidence) begin
            n_out.prop_action = rpg_pkg::RESP_OBSERVE;
            n_out.reason      = rpg_pkg::RSN_LOW_CONF;
        end else if (!r_enforce_mode) begin
            n_out.prop_action = rpg_pkg::RESP_OBSERVE;
            n_out.reason      = rpg_pkg::RSN_OBSERVE;
        end else if (limited) begin
            n_out.prop_action = rpg_pkg::RESP_OBSERVE;
            n_out.reason      = rpg_pkg::RSN_RATE_LIM;
        end else begin
            n_out.prop_action = r_in.req_action;
            n_out.reason      = rpg_pkg::RSN_NONE;
        end

        // observe always passes; real actions need enforce and their mask bit
        case (n_out.prop_action)
            rpg_pkg::RESP_OBSERVE:    allowed = 1'b1;
            rpg_pkg::RESP_KILL:       allowed = r_enforce_mode && r_allow_mask[0];
            rpg_pkg::RESP_QUARANTINE: allowed = r_enforce_mode && r_allow_mask[1];
            rpg_pkg::RESP_BLOCK_NET:  allowed = r_enforce_mode && r_allow_mask[2];
            rpg_pkg::RESP_PREVENT:    allowed = r_enforce_mode && r_allow_mask[3];
            default:                  allowed = 1'b0;
        endcase

        n_out.permitted    = allowed;
        n_out.final_action = n_out.prop_action;
        if (!allowed) begin
            n_out.final_action = rpg_pkg::RESP_OBSERVE;
            n_out.reason       = rpg_pkg::RSN_BLOCKED;
        end
    end

    assign do_log = fire && allowed && (n_out.prop_action != rpg_pkg::RESP_OBSERVE);

    // after logging only in-window entries stay; the new entry is always in window
    always_comb begin
        n_entry_valid = in_window;
        for (int i = 0; i < LOG_DEPTH; i++) begin
            if (r_slot == SLOT_W'(i)) begin
                n_entry_valid[i] = 1'b1;
            end
        end
    end

    assign n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);

    // control and config state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_entry_valid    <= '0;
            r_slot           <= '0;
            r_enforce_mode   <= rpg_pkg::ENFORCE_MODE_RST;
            r_min_confidence <= rpg_pkg::MIN_CONFIDENCE_RST;
            r_max_actions    <= rpg_pkg::MAX_ACTIONS_RST;
            r_window_seconds <= rpg_pkg::WINDOW_SECONDS_RST;
            r_allow_mask     <= rpg_pkg::ALLOW_MASK_RST;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (do_log) begin
                r_entry_valid <= n_entry_valid;
                r_slot        <= n_slot;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rpg_pkg::CFG_ENFORCE_MODE:   r_enforce_mode   <= i_cfg_data[0];
                    rpg_pkg::CFG_MIN_CONFIDENCE: r_min_confidence <= i_cfg_data[10:0];
                    rpg_pkg::CFG_MAX_ACTIONS:    r_max_actions    <= i_cfg_data[4:0];
                    rpg_pkg::CFG_WINDOW_SECONDS: r_window_seconds <= i_cfg_data;
                    rpg_pkg::CFG_ALLOW_MASK:     r_allow_mask     <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
        if (do_log) begin
            r_times[r_slot] <= r_in.now_time;
        end
    end

endmodule

[design/rpg_checker.sv]
// port-level assertions for the response policy gate, bound to the top level
module rpg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input rpg_pkg::t_out_item o_out_data
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a refused response becomes observe with reason blocked
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.permitted |->
            o_out_data.final_action == rpg_pkg::RESP_OBSERVE &&
            o_out_data.reason == rpg_pkg::RSN_BLOCKED)
        else $error("refused response not demoted");

    // a permitted response is carried out as proposed
    a_permitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.permitted |->
            o_out_data.final_action == o_out_data.prop_action &&
            o_out_data.reason != rpg_pkg::RSN_BLOCKED)
        else $error("permitted response altered");

    // any demotion reason leaves an observe proposal
    a_demoted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.reason == rpg_pkg::RSN_UNDEFINED ||
            o_out_data.reason == rpg_pkg::RSN_LOW_CONF ||
            o_out_data.reason == rpg_pkg::RSN_OBSERVE ||
            o_out_data.reason == rpg_pkg::RSN_RATE_LIM) |->
            o_out_data.prop_action == rpg_pkg::RESP_OBSERVE)
        else $error("demoted result proposes an action");

endmodule

bind response_policy_gate_with_rate_limit_core rpg_checker u_rpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
